// File: rtl/mur_pkg.sv
// Shared types and constants for the multi-sonar ranging block.
// No dependencies; every module of the block imports this package.
package mur_pkg;

    // Configuration register indexes.
    localparam logic REG_ACTIVE_COUNT    = 1'b0;
    localparam logic REG_SINGLE_PIN_MASK = 1'b1;

    // Input beat modes.
    localparam logic [1:0] MODE_ECHO    = 2'd0;
    localparam logic [1:0] MODE_TRIGGER = 2'd1;
    localparam logic [1:0] MODE_SCAN    = 2'd2;

    // Command opcodes passed from the front end to the execution unit.
    localparam logic [1:0] OP_ECHO = 2'd0;
    localparam logic [1:0] OP_TRIG = 2'd1;
    localparam logic [1:0] OP_SCAN = 2'd2;

    // Result kinds.
    localparam logic KIND_TRIGGER = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Timing limits in microseconds.
    localparam logic [31:0] SCAN_PERIOD_US = 32'd100000;
    localparam logic [31:0] STALE_LIMIT_US = 32'd1000000;
    localparam logic [31:0] MAX_WIDTH_US   = 32'd30000;
    localparam logic [31:0] NO_DATA        = 32'hFFFF_FFFF;

    // Width to centimeters: multiply by a rounded-up reciprocal of 58 and shift.
    // Exact for every width up to the range limit.
    localparam int          US_PER_CM = 58;
    localparam int          CM_SHIFT  = 21;
    localparam logic [15:0] CM_RECIP  = 16'(((1 << CM_SHIFT) + US_PER_CM - 1) / US_PER_CM);

    // Distance codes.
    localparam logic [15:0] CODE_NO_ECHO    = 16'hFFFC;
    localparam logic [15:0] CODE_OVER_RANGE = 16'hFFFD;
    localparam logic [15:0] CODE_STALE      = 16'hFFFE;

    // Command queue depth.
    localparam int CMD_DEPTH = 2;

    // One queued command.
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  sonar;
        logic        rising;
        logic        release_pin;
        logic [31:0] time_us;
        logic [7:0]  echo_levels;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic        kind;
        logic [2:0]  sonar;
        logic [15:0] distance_code;
        logic        release_pin;
        logic        last;
    } t_result;

endpackage

// File: rtl/mur_in_if.sv
// Input channel of the ranging block: valid/ready handshake with the event payload.
// No dependencies.
interface mur_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  channel;
    logic        rising;
    logic [31:0] time_us;
    logic [7:0]  echo_levels;

    modport source (output valid, mode, channel, rising, time_us, echo_levels,
                    input ready);
    modport sink   (input valid, mode, channel, rising, time_us, echo_levels,
                    output ready);
endinterface

// File: rtl/mur_out_if.sv
// Result channel of the ranging block: valid/ready handshake with the result payload.
// No dependencies.
interface mur_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  sonar;
    logic [15:0] distance_code;
    logic        release_pin;
    logic        last;

    modport source (output valid, kind, sonar, distance_code, release_pin, last,
                    input ready);
    modport sink   (input valid, kind, sonar, distance_code, release_pin, last,
                    output ready);
endinterface

// File: rtl/mur_cmd_fifo.sv
// Short command queue between the front end and the execution unit.
// Depends on mur_pkg for the command type and queue depth.
module mur_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mur_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mur_pkg::t_cmd o_cmd
);
    import mur_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer and fill count update; pointers wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // The front end only pushes when there is room, the back end only pops what is there.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command popped from an empty queue");

endmodule

// File: rtl/mur_front.sv
// Front end: accepts input beats, owns the trigger rotation and scan pacing,
// and turns each beat into a command or drops it. Depends on mur_pkg and mur_in_if.
module mur_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mur_in_if.sink        i_in,
    input  logic [3:0]    i_live_count,
    input  logic [7:0]    i_single_pin_mask,
    input  logic          i_full,
    output logic          o_push,
    output mur_pkg::t_cmd o_cmd
);
    import mur_pkg::*;

    logic [2:0]  r_next_trigger, n_next_trigger;
    logic [31:0] r_scan_mark, n_scan_mark;
    logic        accept;
    logic [2:0]  trig_sonar;
    logic [3:0]  trig_after;
    logic [31:0] scan_elapsed;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // Trigger rotation: fall back to sonar 0 when the count was lowered.
    assign trig_sonar   = ({1'b0, r_next_trigger} >= i_live_count) ? 3'd0 : r_next_trigger;
    assign trig_after   = {1'b0, trig_sonar} + 4'd1;
    assign scan_elapsed = i_in.time_us - r_scan_mark;

    // Classify the beat and build the command.
    always_comb begin
        n_next_trigger    = r_next_trigger;
        n_scan_mark       = r_scan_mark;
        o_push            = 1'b0;
        o_cmd.op          = OP_ECHO;
        o_cmd.sonar       = i_in.channel;
        o_cmd.rising      = i_in.rising;
        o_cmd.release_pin = 1'b0;
        o_cmd.time_us     = i_in.time_us;
        o_cmd.echo_levels = i_in.echo_levels;
        if (accept) begin
            unique case (i_in.mode)
                MODE_ECHO: begin
                    o_push = ({1'b0, i_in.channel} < i_live_count);
                end
                MODE_TRIGGER: begin
                    if (i_live_count != 4'd0) begin
                        o_push            = 1'b1;
                        o_cmd.op          = OP_TRIG;
                        o_cmd.sonar       = trig_sonar;
                        o_cmd.release_pin = i_single_pin_mask[trig_sonar];
                        n_next_trigger    = (trig_after >= i_live_count) ? 3'd0 : trig_after[2:0];
                    end
                end
                MODE_SCAN: begin
                    if (scan_elapsed >= SCAN_PERIOD_US) begin
                        n_scan_mark = r_scan_mark + SCAN_PERIOD_US;
                        o_push      = (i_live_count != 4'd0);
                        o_cmd.op    = OP_SCAN;
                    end
                end
                default: begin
                    // Unused mode: dropped without effect.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_trigger <= '0;
            r_scan_mark    <= '0;
        end else begin
            r_next_trigger <= n_next_trigger;
            r_scan_mark    <= n_scan_mark;
        end
    end

    // A trigger command always names an active sonar.
    a_trig_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.op == OP_TRIG) |-> ({1'b0, o_cmd.sonar} < i_live_count))
        else $error("trigger issued for an inactive sonar");

endmodule

// File: rtl/mur_back.sv
// Execution unit: holds the per-sonar timing state, applies echo edges, emits trigger
// requests, walks a scan one sonar per cycle bar output stalls. Uses mur_pkg, mur_out_if.
module mur_back #(
    parameter int LANES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [3:0]    i_live_count,
    input  logic          i_cmd_valid,
    input  mur_pkg::t_cmd i_cmd,
    output logic          o_pop,
    mur_out_if.source     o_out
);
    import mur_pkg::*;

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Per-sonar state.
    logic [31:0] r_rise_times   [LANES];
    logic [31:0] r_pulse_widths [LANES];
    logic [15:0] r_last_codes   [LANES];

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0]      r_scan_time, n_scan_time;
    logic [7:0]       r_levels, n_levels;
    logic             r_pend_valid, n_pend_valid;
    t_result          r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic [IDX_W-1:0] addr;
    logic [31:0]      rd_rise, rd_width;
    logic [15:0]      rd_code;
    logic             can_move;
    logic             wr_rise, wr_width, wr_code;
    logic [31:0]      wr_width_val;

    logic [31:0] elapsed;
    logic [30:0] cm_prod;
    logic [15:0] scan_code;
    logic        skip, report, step_ok, last_idx;

    // One shared read address: the scan index during a scan, else the command's sonar.
    assign addr     = (r_state == ST_SCAN) ? r_idx : i_cmd.sonar[IDX_W-1:0];
    assign rd_rise  = r_rise_times[addr];
    assign rd_width = r_pulse_widths[addr];
    assign rd_code  = r_last_codes[addr];
    assign can_move = !r_out_valid || o_out.ready;

    // Classification of the sonar under the scan index.
    assign elapsed = r_scan_time - rd_rise;
    assign cm_prod = 31'(rd_width[14:0]) * 31'(CM_RECIP);
    always_comb begin
        if (rd_width == NO_DATA) begin
            scan_code = CODE_NO_ECHO;
        end else if (elapsed > STALE_LIMIT_US) begin
            scan_code = CODE_STALE;
        end else if (rd_width > MAX_WIDTH_US) begin
            scan_code = CODE_OVER_RANGE;
        end else begin
            scan_code = 16'(cm_prod[30:CM_SHIFT]);
        end
    end
    assign skip     = (rd_width == NO_DATA) && r_levels[3'(r_idx)];
    assign report   = !skip && (scan_code != rd_code);
    assign step_ok  = !(report && r_pend_valid && !can_move);
    assign last_idx = (4'(r_idx) == i_live_count - 4'd1);

    // Control sequencer. A found report waits in a pending slot so that the last
    // beat of a scan can be flagged once the walk has ended.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_scan_time  = r_scan_time;
        n_levels     = r_levels;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        o_pop        = 1'b0;
        wr_rise      = 1'b0;
        wr_width     = 1'b0;
        wr_width_val = i_cmd.time_us - rd_rise;
        wr_code      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_ECHO: begin
                            o_pop    = 1'b1;
                            wr_rise  = i_cmd.rising;
                            wr_width = !i_cmd.rising;
                        end
                        OP_TRIG: begin
                            if (can_move) begin
                                o_pop               = 1'b1;
                                n_out_valid         = 1'b1;
                                n_out.kind          = KIND_TRIGGER;
                                n_out.sonar         = i_cmd.sonar;
                                n_out.distance_code = 16'd0;
                                n_out.release_pin   = i_cmd.release_pin;
                                n_out.last          = 1'b1;
                            end
                        end
                        OP_SCAN: begin
                            o_pop       = 1'b1;
                            n_state     = ST_SCAN;
                            n_idx       = '0;
                            n_scan_time = i_cmd.time_us;
                            n_levels    = i_cmd.echo_levels;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (step_ok) begin
                    if (report) begin
                        wr_code      = 1'b1;
                        wr_width     = 1'b1;
                        wr_width_val = NO_DATA;
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                        end
                        n_pend_valid         = 1'b1;
                        n_pend.kind          = KIND_REPORT;
                        n_pend.sonar         = 3'(r_idx);
                        n_pend.distance_code = scan_code;
                        n_pend.release_pin   = 1'b0;
                        n_pend.last          = 1'b0;
                    end
                    if (last_idx) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (can_move) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out.last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_scan_time <= n_scan_time;
        r_levels    <= n_levels;
        r_pend      <= n_pend;
        r_out       <= n_out;
    end

    // Per-sonar state clears to zero on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_rise_times[i]   <= '0;
                r_pulse_widths[i] <= '0;
                r_last_codes[i]   <= '0;
            end
        end else begin
            if (wr_rise) begin
                r_rise_times[addr] <= i_cmd.time_us;
            end
            if (wr_width) begin
                r_pulse_widths[addr] <= wr_width_val;
            end
            if (wr_code) begin
                r_last_codes[addr] <= scan_code;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.sonar         = r_out.sonar;
    assign o_out.distance_code = r_out.distance_code;
    assign o_out.release_pin   = r_out.release_pin;
    assign o_out.last          = r_out.last;

    // A pending report never outlives its scan.
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("pending report left behind after a scan");
    // The scan index stays within the active sonars.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (4'(r_idx) < i_live_count))
        else $error("scan index beyond the active count");
    // Trigger requests carry no distance and are always the final beat.
    a_trig_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_TRIGGER) |->
            (r_out.distance_code == 16'd0 && r_out.last))
        else $error("malformed trigger request");
    // Distance reports never ask for a pin release.
    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_REPORT) |-> !r_out.release_pin)
        else $error("distance report with pin release set");

endmodule

// File: rtl/multi_ultrasonic_ranger.sv
// Echo timing and distance reporting for up to eight ultrasonic rangers. Each
// input beat is an echo edge, a trigger tick or a scan tick; the front end takes
// one beat per cycle while its two-entry command queue has room. In the back
// end an echo edge updates its sonar's timing state, a trigger tick waits for
// the output register, and a scan starts, walks the active sonars (up to eight)
// and flushes its final report; the walk can stall while the result side holds
// off. Configuration writes are taken at any time but must only change while
// the block is idle. There is no clearing pass after reset. Depends on mur_pkg,
// mur_in_if, mur_out_if and the mur_* modules.
module multi_ultrasonic_ranger #(
    parameter int NUM_SONARS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mur_in_if.sink     i_in,
    mur_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import mur_pkg::*;

    localparam int LANES = (NUM_SONARS < 8) ? NUM_SONARS : 8;

    logic [3:0] r_active_count;
    logic [7:0] r_single_pin_mask;
    logic [3:0] live_count;
    logic       push, full, pop, cmd_valid;
    t_cmd       push_cmd, head_cmd;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count    <= '0;
            r_single_pin_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ACTIVE_COUNT:    r_active_count    <= i_cfg_data[3:0];
                REG_SINGLE_PIN_MASK: r_single_pin_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Active count capped at the number of built sonars.
    assign live_count = (r_active_count > 4'(LANES)) ? 4'(LANES) : r_active_count;

    mur_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (i_in),
        .i_live_count      (live_count),
        .i_single_pin_mask (r_single_pin_mask),
        .i_full            (full),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    mur_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    mur_back #(
        .LANES (LANES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_live_count (live_count),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
